@@ rtl/array_deque_engine_core_assert.svh @@
// Assertion macros used by the deque engine checker.
`ifndef ARRAY_DEQUE_ENGINE_CORE_ASSERT_SVH
`define ARRAY_DEQUE_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, muted while arst_n is low.
`define ADE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, muted while arst_n is low.
`define ADE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/ade_pkg.sv @@
// Shared types and constants of the deque engine.
`timescale 1ns / 1ps
`default_nettype none
package ade_pkg;

	localparam int DATA_W   = 32;
	localparam int FUNC_W   = 3;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 8;

	// request codes
	localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_NOP        = 3'd4;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NOFRONT   = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd3;

	// controller to datapath commands
	typedef struct packed {
		logic load;  // capture the accepted request
		logic exec;  // update indices, write or read the store
		logic resp;  // fold read data into caches, load result register
	} ade_cmd_t;

endpackage
`default_nettype wire

@@ rtl/ade_if.sv @@
// Request and result channel interfaces of the deque engine.
`timescale 1ns / 1ps
`default_nettype none
interface ade_req_if
	import ade_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink   (input valid, input func, input value, output ready);
endinterface

interface ade_rsp_if
	import ade_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic [STATUS_W-1:0]      status;
	logic signed [DATA_W-1:0] removed_value;
	logic signed [DATA_W-1:0] front_value;
	logic signed [DATA_W-1:0] back_value;
	logic [COUNT_W-1:0]       count;
	logic                     is_empty;

	modport source (output valid, output status, output removed_value, output front_value,
		output back_value, output count, output is_empty, input ready);
	modport sink   (input valid, input status, input removed_value, input front_value,
		input back_value, input count, input is_empty, output ready);
endinterface
`default_nettype wire

@@ rtl/ade_ctrl.sv @@
// Sequencing state machine of the deque engine.
`timescale 1ns / 1ps
`default_nettype none
module ade_ctrl
	import ade_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output ade_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nx;
	logic       rsp_valid_q;
	logic       slot_free;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd.load = (state_q == S_IDLE) && req_valid;
		cmd.exec = (state_q == S_EXEC);
		cmd.resp = (state_q == S_RESP) && slot_free;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_nx = S_EXEC;
			end
			S_EXEC: state_nx = S_RESP;
			S_RESP: begin
				if (slot_free) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.resp) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

@@ rtl/ade_dp.sv @@
// Deque datapath: indices, element store, end caches and result register.
`timescale 1ns / 1ps
`default_nettype none
module ade_dp
	import ade_pkg::*;
#(
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire ade_cmd_t                 cmd,
	input  wire logic [FUNC_W-1:0]        req_func,
	input  wire logic signed [DATA_W-1:0] req_value,
	output logic [STATUS_W-1:0]           status,
	output logic signed [DATA_W-1:0]      removed_value,
	output logic signed [DATA_W-1:0]      front_value,
	output logic signed [DATA_W-1:0]      back_value,
	output logic [COUNT_W-1:0]            count,
	output logic                          is_empty
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = (IW + 1 > COUNT_W) ? IW + 1 : COUNT_W;
	localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

	// captured request
	logic [FUNC_W-1:0]        func_q;
	logic signed [DATA_W-1:0] value_q;

	// deque state
	logic [IW-1:0] head_q, tail_q;
	logic          empty_q;
	logic [DATA_W-1:0] front_q, back_q;  // copies of store[head], store[tail]

	// per-item results carried from execute to respond
	logic [STATUS_W-1:0] status_q;
	logic [DATA_W-1:0]   removed_q;
	logic                upd_front_q, upd_back_q;

	// element store
	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_q;

	// execute-step decisions
	logic [IW-1:0]       head_nx, tail_nx;
	logic                empty_nx;
	logic [DATA_W-1:0]   front_nx, back_nx;
	logic [STATUS_W-1:0] status_nx;
	logic [DATA_W-1:0]   removed_nx;
	logic                wr_en, rd_en, upd_front_nx, upd_back_nx;
	logic [IW-1:0]       wr_addr, rd_addr;

	// respond-step values
	logic [DATA_W-1:0] front_fin, back_fin;
	logic [CW-1:0]     cnt_full;

	always_comb begin
		head_nx      = head_q;
		tail_nx      = tail_q;
		empty_nx     = empty_q;
		front_nx     = front_q;
		back_nx      = back_q;
		status_nx    = STAT_OK;
		removed_nx   = '0;
		wr_en        = 1'b0;
		wr_addr      = '0;
		rd_en        = 1'b0;
		rd_addr      = '0;
		upd_front_nx = 1'b0;
		upd_back_nx  = 1'b0;
		case (func_q)
			FN_PUSH_FRONT: begin
				if (empty_q) begin
					head_nx  = '0;
					tail_nx  = '0;
					empty_nx = 1'b0;
					wr_en    = 1'b1;
					front_nx = value_q;
					back_nx  = value_q;
				end else if (head_q == '0 && tail_q == LAST) begin
					status_nx = STAT_OVERFLOW;
				end else if (head_q != '0) begin
					head_nx  = head_q - IW'(1);
					wr_en    = 1'b1;
					wr_addr  = head_q - IW'(1);
					front_nx = value_q;
				end else begin
					status_nx = STAT_NOFRONT;
				end
			end
			FN_PUSH_BACK: begin
				if (empty_q) begin
					head_nx  = '0;
					tail_nx  = '0;
					empty_nx = 1'b0;
					wr_en    = 1'b1;
					front_nx = value_q;
					back_nx  = value_q;
				end else if (tail_q == LAST) begin
					status_nx = STAT_OVERFLOW;
				end else begin
					tail_nx = tail_q + IW'(1);
					wr_en   = 1'b1;
					wr_addr = tail_q + IW'(1);
					back_nx = value_q;
				end
			end
			FN_POP_FRONT, FN_POP_BACK: begin
				if (empty_q) begin
					status_nx = STAT_UNDERFLOW;
				end else begin
					removed_nx = (func_q == FN_POP_FRONT) ? front_q : back_q;
					if (head_q == tail_q) begin
						head_nx  = '0;
						tail_nx  = '0;
						empty_nx = 1'b1;
					end else if (func_q == FN_POP_FRONT) begin
						// new front comes back from the store next cycle
						head_nx      = head_q + IW'(1);
						rd_en        = 1'b1;
						rd_addr      = head_q + IW'(1);
						upd_front_nx = 1'b1;
					end else begin
						tail_nx     = tail_q - IW'(1);
						rd_en       = 1'b1;
						rd_addr     = tail_q - IW'(1);
						upd_back_nx = 1'b1;
					end
				end
			end
			default: ;  // no operation, including unused codes
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else if (cmd.exec) begin
			head_q  <= head_nx;
			tail_q  <= tail_nx;
			empty_q <= empty_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && cmd.exec) mem_q[wr_addr] <= value_q;
		if (rd_en && cmd.exec) rd_q <= mem_q[rd_addr];
	end

	assign front_fin = upd_front_q ? rd_q : front_q;
	assign back_fin  = upd_back_q ? rd_q : back_q;
	assign cnt_full  = CW'(tail_q) - CW'(head_q) + CW'(1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= req_func;
			value_q <= req_value;
		end
		if (cmd.exec) begin
			front_q     <= front_nx;
			back_q      <= back_nx;
			status_q    <= status_nx;
			removed_q   <= removed_nx;
			upd_front_q <= upd_front_nx;
			upd_back_q  <= upd_back_nx;
		end
		if (cmd.resp) begin
			front_q       <= front_fin;
			back_q        <= back_fin;
			status        <= status_q;
			removed_value <= removed_q;
			front_value   <= empty_q ? '1 : front_fin;
			back_value    <= empty_q ? '1 : back_fin;
			count         <= empty_q ? '0 : cnt_full[COUNT_W-1:0];
			is_empty      <= empty_q;
		end
	end

endmodule
`default_nettype wire

@@ rtl/array_deque_engine_core.sv @@
// Top level of the array-based double-ended queue engine.
`timescale 1ns / 1ps
`default_nettype none
// Double-ended queue over a fixed, non-circular array of DEPTH 32-bit slots.
// Each request item on req pushes at the front or back, pops from the front or
// back, or does nothing; each request yields exactly one result item on rsp with
// the status, the popped value (zero unless a pop succeeded), the front and back
// values after the request (-1 when empty), the count and an empty flag.
// Push front is refused with "no space at front" while the front sits at slot 0
// and the deque is neither empty nor full; a push onto a full array, or a push
// back with the rear at the last slot, reports overflow; a pop of an empty deque
// reports underflow. Removing the last element returns both indices to slot 0.
// Sequence: an item passes through three steps (capture, index update with one
// store access, return of the read data); its result is loaded into the output
// register once that register is free. req.ready is high only while the engine
// is idle, so no new item is taken until the previous one has completed its
// final step; the sequence is set by the registered read of the single element
// store, which must return the new front or back after a pop. A result waiting
// in the output register does not block acceptance; only the final step waits
// for that register to free up. Store slots need no clearing: only slots between
// front and rear are ever read, and those were written. The count is reported
// modulo 256.
module array_deque_engine_core
	import ade_pkg::*;
#(
	parameter int DEPTH = 128
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ade_req_if.sink   req,
	ade_rsp_if.source rsp
);

	ade_cmd_t cmd;

	// sequencing: idle -> execute -> respond
	ade_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// indices, store, end caches and result register
	ade_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.req_func      (req.func),
		.req_value     (req.value),
		.status        (rsp.status),
		.removed_value (rsp.removed_value),
		.front_value   (rsp.front_value),
		.back_value    (rsp.back_value),
		.count         (rsp.count),
		.is_empty      (rsp.is_empty)
	);

endmodule
`default_nettype wire

@@ rtl/array_deque_engine_core_checker.sv @@
// Port-level assertion checker for the deque engine, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "array_deque_engine_core_assert.svh"
module array_deque_engine_core_checker
	import ade_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     req_valid,
	input wire logic                     req_ready,
	input wire logic                     rsp_valid,
	input wire logic                     rsp_ready,
	input wire logic [STATUS_W-1:0]      rsp_status,
	input wire logic signed [DATA_W-1:0] rsp_removed_value,
	input wire logic signed [DATA_W-1:0] rsp_front_value,
	input wire logic signed [DATA_W-1:0] rsp_back_value,
	input wire logic [COUNT_W-1:0]       rsp_count,
	input wire logic                     rsp_is_empty
);

	// a pending result stays offered until taken
	`ADE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
	// one item at a time: no second accept right after one
	`ADE_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "back-to-back accept")
	// empty result shows the empty markers
	`ADE_ASSERT_NOW(a_empty_view, rsp_valid && rsp_is_empty, rsp_count == '0 && rsp_front_value == -1 && rsp_back_value == -1, "bad empty result")
	// underflow only on an empty deque and removes nothing
	`ADE_ASSERT_NOW(a_underflow, rsp_valid && rsp_status == STAT_UNDERFLOW, rsp_is_empty && rsp_removed_value == '0, "bad underflow result")
	// a single element is both front and back
	`ADE_ASSERT_NOW(a_single, rsp_valid && !rsp_is_empty && rsp_count == 8'd1, rsp_front_value == rsp_back_value, "front and back differ")

endmodule

bind array_deque_engine_core array_deque_engine_core_checker u_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_removed_value (rsp.removed_value),
	.rsp_front_value   (rsp.front_value),
	.rsp_back_value    (rsp.back_value),
	.rsp_count         (rsp.count),
	.rsp_is_empty      (rsp.is_empty)
);
`default_nettype wire
